### rtl/mmixod_pkg.sv
// Shared types for the MMIX operand decoder: argument classes, operand formats,
// transfer payload structs and the decode info passed between modules.
// No dependencies.
package mmixod_pkg;

  typedef enum logic [3:0] {
    CLS_DSS    = 4'd0,
    CLS_DS     = 4'd1,
    CLS_DA     = 4'd2,
    CLS_SA     = 4'd3,
    CLS_CT     = 4'd4,
    CLS_A      = 4'd5,
    CLS_III    = 4'd6,
    CLS_LA     = 4'd7,
    CLS_MA     = 4'd8,
    CLS_SAVE   = 4'd9,
    CLS_UNSAVE = 4'd10,
    CLS_S      = 4'd11
  } arg_class_t;

  typedef enum logic [4:0] {
    FMT_I8I8I8 = 5'd0,
    FMT_RRR    = 5'd1,
    FMT_RI8R   = 5'd2,
    FMT_RI8I8  = 5'd3,
    FMT_RRI8   = 5'd4,
    FMT_RF16   = 5'd5,
    FMT_RB16   = 5'd6,
    FMT_I8RR   = 5'd7,
    FMT_I8RI8  = 5'd8,
    FMT_RI16   = 5'd9,
    FMT_F24    = 5'd10,
    FMT_B24    = 5'd11,
    FMT_S80R   = 5'd12,
    FMT_S80I8  = 5'd13,
    FMT_I8I16  = 5'd14,
    FMT_00I8   = 5'd15,
    FMT_R0I8   = 5'd16,
    FMT_I80R   = 5'd17,
    FMT_I24    = 5'd18,
    FMT_R0S8   = 5'd19
  } format_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [63:0] pc_value;
    logic [63:0] reg_x_value;
    logic [63:0] reg_y_value;
    logic [63:0] reg_z_value;
    logic [63:0] return_jump;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  opcode_out;
    logic [3:0]  arg_class;
    logic [4:0]  format_code;
    logic [63:0] x_operand;
    logic [63:0] y_operand;
    logic [63:0] z_operand;
    logic        rule_trap;
  } out_item_t;

  // Classifier result handed to the operand former.
  typedef struct packed {
    arg_class_t cls;
    format_t    fmt;
    logic       trap;
  } dec_info_t;

endpackage

### rtl/mmix_operand_decoder.sv
// MMIX operand decoder top level: input register, operand former, result register.
// Depends on mmixod_pkg and mmixod_operand.
//
// Decodes one MMIX instruction per transfer. The caller presents the 32-bit
// instruction word with its PC, rJ and the X/Y/Z register values already
// read from the register file; the block returns the opcode, argument class,
// operand format, the x/y/z operands and the rules-breaking trap flag. When
// the trap is set all three operands are zero. Throughput is one instruction
// per cycle while out_ready is high. An accepted instruction is held in the
// input register, decoded combinationally (opcode map plus one 64-bit add
// and a select per operand) and captured in the result register, which
// drives out_valid and out_data. Both stages advance whenever the stage
// after them is empty or draining, so in_ready follows out_ready
// combinationally through the two stage flags. Sums and relative targets
// wrap modulo 2^64. No configuration, no state beyond the two pipeline
// registers.
module mmix_operand_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mmixod_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mmixod_pkg::out_item_t out_data
);
  import mmixod_pkg::*;

  // Stage 1: captured instruction.
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  // Stage 2: decoded result.
  logic      s2_valid_r;
  out_item_t s2_data_r;

  logic      s2_ready;
  logic      s1_ready;
  out_item_t dec_result;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  mmixod_operand u_operand (
    .item   (s1_data_r),
    .result (dec_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers load only on a transfer into their stage.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= dec_result;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

  // Trap forces all operands to zero.
  a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rule_trap |->
      out_data.x_operand == 64'd0 && out_data.y_operand == 64'd0 &&
      out_data.z_operand == 64'd0)
    else $error("trap with nonzero operand");

  // Class III only comes with the all-immediate format.
  a_iii_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.arg_class == CLS_III |->
      out_data.format_code == FMT_I8I8I8)
    else $error("class III with wrong format");

  // An accepted instruction occupies stage 1 on the next cycle.
  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted item lost at stage 1");

  // A full stage 1 behind a stalled result holds its instruction.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(s1_data_r))
    else $error("stage 1 changed while stalled");

endmodule

### rtl/mmixod_classify.sv
// Opcode map lookup: argument class, operand format and reserved-field trap.
// Depends on mmixod_pkg.
module mmixod_classify (
  input  logic [31:0]           instr_word,
  output mmixod_pkg::dec_info_t info
);
  import mmixod_pkg::*;

  logic [7:0] op;
  logic [7:0] bx;
  logic [7:0] by;
  logic       odd;
  format_t    fmt_rr;
  format_t    fmt_ir;
  format_t    fmt_rel;
  arg_class_t cls;
  format_t    fmt;

  assign op      = instr_word[31:24];
  assign bx      = instr_word[23:16];
  assign by      = instr_word[15:8];
  assign odd     = op[0];
  assign fmt_rr  = odd ? FMT_RRI8 : FMT_RRR;
  assign fmt_ir  = odd ? FMT_I8RI8 : FMT_I8RR;
  assign fmt_rel = odd ? FMT_RB16 : FMT_RF16;

  always_comb begin
    cls = CLS_DSS;
    fmt = fmt_rr;
    if (op inside {8'h00, 8'hFD, 8'hFF}) begin
      cls = CLS_III;
      fmt = FMT_I8I8I8;
    end else if (op < 8'h18) begin
      if (op inside {8'h05, 8'h07, 8'h08, 8'h0A, 8'h0C, 8'h0E, 8'h15, 8'h17}) begin
        cls = CLS_DS;
        fmt = FMT_RI8R;
      end else if (op inside {8'h09, 8'h0B, 8'h0D, 8'h0F}) begin
        cls = CLS_DS;
        fmt = FMT_RI8I8;
      end else begin
        fmt = FMT_RRR;
      end
    end else if (op inside {[8'h34:8'h37]}) begin
      fmt = odd ? FMT_RI8I8 : FMT_RI8R;
    end else if (op < 8'h40) begin
      cls = CLS_DSS;
    end else if (op < 8'h60) begin
      cls = CLS_CT;
      fmt = fmt_rel;
    end else if (op < 8'h80) begin
      cls = CLS_DSS;
    end else if (op < 8'h94 || op == 8'h96 || op == 8'h97) begin
      cls = CLS_DA;
    end else if (op < 8'h9A || op == 8'h9E || op == 8'h9F) begin
      cls = CLS_DSS;
    end else if (op < 8'h9E) begin
      cls = CLS_LA;
      fmt = fmt_ir;
    end else if (op == 8'hB4 || op == 8'hB5) begin
      cls = CLS_SA;
      fmt = fmt_ir;
    end else if (op < 8'hB8) begin
      cls = CLS_SA;
    end else if (op < 8'hBE) begin
      cls = CLS_LA;
      fmt = fmt_ir;
    end else if (op < 8'hC0) begin
      cls = CLS_MA;
    end else if (op < 8'hE0) begin
      cls = CLS_DSS;
    end else if (op < 8'hF0) begin
      cls = CLS_DS;
      fmt = FMT_RI16;
    end else begin
      case (op)
        8'hF0: begin cls = CLS_A;      fmt = FMT_F24;   end
        8'hF1: begin cls = CLS_A;      fmt = FMT_B24;   end
        8'hF2, 8'hF3: begin cls = CLS_MA; fmt = fmt_rel; end
        8'hF4, 8'hF5: begin cls = CLS_DA; fmt = fmt_rel; end
        8'hF6: begin cls = CLS_DS;     fmt = FMT_S80R;  end
        8'hF7: begin cls = CLS_DS;     fmt = FMT_S80I8; end
        8'hF8: begin cls = CLS_MA;     fmt = FMT_I8I16; end
        8'hF9: begin cls = CLS_S;      fmt = FMT_00I8;  end
        8'hFA: begin cls = CLS_SAVE;   fmt = FMT_R0I8;  end
        8'hFB: begin cls = CLS_UNSAVE; fmt = FMT_I80R;  end
        8'hFC: begin cls = CLS_S;      fmt = FMT_I24;   end
        default: begin cls = CLS_DS;   fmt = FMT_R0S8;  end
      endcase
    end
  end

  // Reserved Y (and for RESUME also X) must be zero.
  always_comb begin
    info.cls  = cls;
    info.fmt  = fmt;
    info.trap = 1'b0;
    case (cls)
      CLS_DS: begin
        info.trap = (fmt == FMT_R0S8 || fmt == FMT_S80I8 || fmt == FMT_S80R) &&
                    (by != 8'd0);
      end
      CLS_SAVE, CLS_UNSAVE: begin
        info.trap = (by != 8'd0);
      end
      CLS_S: begin
        info.trap = (fmt == FMT_00I8) && ((bx != 8'd0) || (by != 8'd0));
      end
      default: begin
        info.trap = 1'b0;
      end
    endcase
  end

endmodule

### rtl/mmixod_operand.sv
// Operand former: adders, relative targets and per-class operand selection.
// Depends on mmixod_pkg and mmixod_classify.
module mmixod_operand (
  input  mmixod_pkg::in_item_t  item,
  output mmixod_pkg::out_item_t result
);
  import mmixod_pkg::*;

  dec_info_t   info;
  logic [63:0] bx;
  logic [63:0] by;
  logic [63:0] bz;
  logic [63:0] l16;
  logic [63:0] l24;
  logic [63:0] sum_yz;
  logic [63:0] sum_yb;
  logic [63:0] off16;
  logic [63:0] off24;
  logic [63:0] rel16;
  logic [63:0] rel24;
  logic [63:0] jump_tgt;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] z;

  mmixod_classify u_classify (
    .instr_word (item.instr_word),
    .info       (info)
  );

  assign bx  = {56'd0, item.instr_word[23:16]};
  assign by  = {56'd0, item.instr_word[15:8]};
  assign bz  = {56'd0, item.instr_word[7:0]};
  assign l16 = {48'd0, item.instr_word[15:0]};
  assign l24 = {40'd0, item.instr_word[23:0]};

  assign sum_yz = item.reg_y_value + item.reg_z_value;
  assign sum_yb = item.reg_y_value + bz;

  // Backward literal minus span is the literal with all upper bits set.
  assign off16    = {{48{info.fmt == FMT_RB16}}, item.instr_word[15:0]};
  assign off24    = {{40{info.fmt == FMT_B24}}, item.instr_word[23:0]};
  assign rel16    = item.pc_value + {off16[61:0], 2'b00};
  assign rel24    = item.pc_value + {off24[61:0], 2'b00};
  assign jump_tgt = item.return_jump + {l16[61:0], 2'b00};

  always_comb begin
    x = 64'd0;
    y = 64'd0;
    z = 64'd0;
    case (info.cls)
      CLS_DSS: begin
        x = bx;
        y = (info.fmt == FMT_RI8I8 || info.fmt == FMT_RI8R) ? by : item.reg_y_value;
        z = (info.fmt == FMT_RRI8 || info.fmt == FMT_RI8I8) ? bz : item.reg_z_value;
      end
      CLS_DS: begin
        x = bx;
        case (info.fmt)
          FMT_RI16:  z = l16;
          FMT_RI8R:  begin y = by; z = item.reg_z_value; end
          FMT_RI8I8: begin y = by; z = bz; end
          FMT_S80R:  z = item.reg_z_value;
          default:   z = bz;
        endcase
      end
      CLS_DA: begin
        x = bx;
        case (info.fmt)
          FMT_RRR:  y = sum_yz;
          FMT_RRI8: y = sum_yb;
          default:  y = rel16;
        endcase
      end
      CLS_SA: begin
        x = (info.fmt == FMT_RRR || info.fmt == FMT_RRI8) ? item.reg_x_value : bx;
        y = (info.fmt == FMT_RRR || info.fmt == FMT_I8RR) ? sum_yz : sum_yb;
      end
      CLS_CT: begin
        x = item.reg_x_value;
        z = rel16;
      end
      CLS_A: begin
        z = rel24;
      end
      CLS_III: begin
        x = bx;
        y = by;
        z = bz;
      end
      CLS_LA: begin
        x = bx;
        z = (info.fmt == FMT_I8RI8) ? sum_yb : sum_yz;
      end
      CLS_MA: begin
        x = bx;
        case (info.fmt)
          FMT_RRI8:  z = sum_yb;
          FMT_RRR:   z = sum_yz;
          FMT_I8I16: z = jump_tgt;
          default:   z = rel16;
        endcase
      end
      CLS_SAVE: begin
        x = bx;
        z = bz;
      end
      CLS_UNSAVE: begin
        x = bx;
        y = item.reg_z_value;
      end
      default: begin
        y = (info.fmt == FMT_00I8) ? bz : l24;
      end
    endcase
  end

  always_comb begin
    result.opcode_out  = item.instr_word[31:24];
    result.arg_class   = info.cls;
    result.format_code = info.fmt;
    result.x_operand   = info.trap ? 64'd0 : x;
    result.y_operand   = info.trap ? 64'd0 : y;
    result.z_operand   = info.trap ? 64'd0 : z;
    result.rule_trap   = info.trap;
  end

endmodule
